FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the power bisector side predicate RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while the active-low reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("%m: implication check failed");

// Next-cycle implication, disabled while the active-low reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

FILE: rtl/core/pbs_pkg.sv
// Package for the power bisector side predicate core: types, codes and defaults.
// No dependencies; used by pbs_split_mul and the top level.
`default_nettype none

package pbs_pkg;

    localparam int COORD_BITS_DEF    = 16;
    localparam int WEIGHT_BITS_DEF   = 32;

    localparam int FIELD_COORD_BITS  = 16;
    localparam int FIELD_WEIGHT_BITS = 32;
    localparam int S_TDATA_BITS      = 192;
    localparam int M_TDATA_BITS      = 8;
    localparam int CFG_INDEX_BITS    = 2;
    localparam int CFG_DATA_BITS     = 32;

    typedef enum logic [1:0] {
        SIDE_NEG  = 2'd0,
        SIDE_ZERO = 2'd1,
        SIDE_POS  = 2'd2
    } t_side;

    typedef enum logic {
        CMD_POINT   = 1'b0,
        CMD_SEGMENT = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        CFG_SITE_X      = 2'd0,
        CFG_SITE_Y      = 2'd1,
        CFG_SITE_WEIGHT = 2'd2
    } t_cfg_index;

    // Load enables for the two register stages of a split multiplier.
    typedef struct packed {
        logic load_pp;
        logic load_sum;
    } t_mul_en;

    function automatic t_side side_of(input logic neg, input logic zero);
        t_side s;
        if (zero) begin
            s = SIDE_ZERO;
        end else if (neg) begin
            s = SIDE_NEG;
        end else begin
            s = SIDE_POS;
        end
        return s;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/pbs_split_mul.sv
// Two-stage signed multiplier that splits the wide operand into halves.
// Depends on pbs_pkg for the load enable struct.
`default_nettype none

module pbs_split_mul #(
    parameter int A_BITS = 17,
    parameter int B_BITS = 54
) (
    input  wire logic                         i_clk,
    input  wire pbs_pkg::t_mul_en             i_en,
    input  wire logic signed [A_BITS-1:0]     i_a,
    input  wire logic signed [B_BITS-1:0]     i_b,
    output logic signed [A_BITS+B_BITS-1:0]   o_p
);

    localparam int LO_BITS  = B_BITS / 2;
    localparam int HI_BITS  = B_BITS - LO_BITS;
    localparam int PLO_BITS = A_BITS + LO_BITS + 1;
    localparam int PHI_BITS = A_BITS + HI_BITS;
    localparam int P_BITS   = A_BITS + B_BITS;

    logic signed [LO_BITS:0]     w_b_lo;
    logic signed [HI_BITS-1:0]   w_b_hi;
    logic signed [PLO_BITS-1:0]  r_pp_lo;
    logic signed [PHI_BITS-1:0]  r_pp_hi;
    logic signed [PLO_BITS-1:0]  n_pp_lo;
    logic signed [PHI_BITS-1:0]  n_pp_hi;
    logic signed [P_BITS-1:0]    r_p;
    logic signed [P_BITS-1:0]    n_p;

    // The low half is an unsigned digit; the high half carries the sign.
    assign w_b_lo = $signed({1'b0, i_b[LO_BITS-1:0]});
    assign w_b_hi = i_b[B_BITS-1:LO_BITS];

    always_comb begin
        n_pp_lo = PLO_BITS'(i_a) * PLO_BITS'(w_b_lo);
        n_pp_hi = PHI_BITS'(i_a) * PHI_BITS'(w_b_hi);
        n_p     = (P_BITS'(r_pp_hi) <<< LO_BITS) + P_BITS'(r_pp_lo);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.load_pp) begin
            r_pp_lo <= n_pp_lo;
            r_pp_hi <= n_pp_hi;
        end
        if (i_en.load_sum) begin
            r_p <= n_p;
        end
    end

    assign o_p = r_p;

endmodule

`default_nettype wire

FILE: rtl/core/power_bisector_side_predicate_core.sv
// Top level of the power bisector side predicate: exact sign of the power
// bisector tests in a nine-stage pipeline. Depends on pbs_pkg, pbs_split_mul
// and assert_macros.svh.
//
//   Channel   Direction  Handshake                Payload
//   s_axis    in         tvalid / tready          tuser: command; tdata: sites, query
//   m_axis    out        tvalid / tready          tdata: side
//   cfg       in         i_cfg_we (no wait)       site x, site y, site weight
//
// Output valid rises once the item has passed through every stage register in order;
// one item per cycle is sustained while i_m_axis_tready stays high.
// The depth is set by the chain of products: differences,
// first products, sums, second products, bisector terms, the split wide
// multipliers (two stages), the numerator sum and the sign stage.
// Each stage loads when it is empty or the stage after it moves, so a stalled
// output only holds back the items behind it and bubbles close up.
// Reset (synchronous, active low) clears the valid bits and the site registers.
`default_nettype none

`include "assert_macros.svh"

module power_bisector_side_predicate_core #(
    parameter int COORD_BITS  = pbs_pkg::COORD_BITS_DEF,
    parameter int WEIGHT_BITS = pbs_pkg::WEIGHT_BITS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // Input stream.
    input  wire logic                                i_s_axis_tvalid,
    output logic                                     o_s_axis_tready,
    // tdata: second_x, second_y, second_weight, third_x, third_y, third_weight,
    //        query_ax, query_ay, query_bx, query_by (lowest bits first)
    input  wire logic [pbs_pkg::S_TDATA_BITS-1:0]    i_s_axis_tdata,
    // tuser: command
    input  wire logic                                i_s_axis_tuser,
    // Output stream.
    output logic                                     o_m_axis_tvalid,
    input  wire logic                                i_m_axis_tready,
    // tdata: side, zero padded to a byte
    output logic [pbs_pkg::M_TDATA_BITS-1:0]         o_m_axis_tdata,
    // Configuration writes.
    input  wire logic                                i_cfg_we,
    input  wire logic [pbs_pkg::CFG_INDEX_BITS-1:0]  i_cfg_index,
    input  wire logic [pbs_pkg::CFG_DATA_BITS-1:0]   i_cfg_data
);

    localparam int FC = pbs_pkg::FIELD_COORD_BITS;
    localparam int FW = pbs_pkg::FIELD_WEIGHT_BITS;
    localparam int C  = COORD_BITS;
    localparam int W  = WEIGHT_BITS;

    // Field offsets within the input tdata.
    localparam int OFF_P2X = 0;
    localparam int OFF_P2Y = OFF_P2X + FC;
    localparam int OFF_W2  = OFF_P2Y + FC;
    localparam int OFF_P3X = OFF_W2 + FW;
    localparam int OFF_P3Y = OFF_P3X + FC;
    localparam int OFF_W3  = OFF_P3Y + FC;
    localparam int OFF_AX  = OFF_W3 + FW;
    localparam int OFF_AY  = OFF_AX + FC;
    localparam int OFF_BX  = OFF_AY + FC;
    localparam int OFF_BY  = OFF_BX + FC;

    // Exact widths of the intermediate values.
    localparam int D1   = C + 1;
    localparam int DU   = C + 2;
    localparam int WD   = W + 1;
    localparam int P0   = D1 + DU;
    localparam int PP   = 2 * D1;
    localparam int PC   = C + D1;
    localparam int E0   = ((P0 + 1 > WD) ? P0 + 1 : WD) + 1;
    localparam int DEN  = PP + 3;
    localparam int T11  = ((PP + 1 > WD) ? PP + 1 : WD) + 1;
    localparam int CW   = PC + 1;
    localparam int T4C  = D1 + CW;
    localparam int T5T  = D1 + T11;
    localparam int T12  = ((T4C + 1 > T5T) ? T4C + 1 : T5T) + 1;
    localparam int XW   = D1 + T12;
    localparam int ZW   = DEN + T11;
    localparam int NW   = ((XW + 2 > ZW) ? XW + 2 : ZW) + 1;

    localparam int NST        = 9;
    localparam int ST_MUL_PP  = 6;
    localparam int ST_MUL_SUM = 7;
    localparam int ST_FLAGS   = 4;

    // ---------------- configuration registers ----------------
    logic [FC-1:0] r_site_x;
    logic [FC-1:0] r_site_y;
    logic [FW-1:0] r_site_weight;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_site_x      <= '0;
            r_site_y      <= '0;
            r_site_weight <= '0;
        end else if (i_cfg_we) begin
            case (pbs_pkg::t_cfg_index'(i_cfg_index))
                pbs_pkg::CFG_SITE_X:      r_site_x      <= i_cfg_data[FC-1:0];
                pbs_pkg::CFG_SITE_Y:      r_site_y      <= i_cfg_data[FC-1:0];
                pbs_pkg::CFG_SITE_WEIGHT: r_site_weight <= i_cfg_data[FW-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- stage control ----------------
    logic [NST:1] r_vld;
    logic [NST:1] en;

    always_comb begin
        en[NST] = !r_vld[NST] || i_m_axis_tready;
        for (int k = NST - 1; k >= 1; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[1]) begin
                r_vld[1] <= i_s_axis_tvalid;
            end
            for (int k = 2; k <= NST; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_s_axis_tready = en[1];
    assign o_m_axis_tvalid = r_vld[NST];

    // Command and sign flags travel beside the data.
    pbs_pkg::t_cmd  r_cmd      [1:NST];
    pbs_pkg::t_side r_side0    [ST_FLAGS:NST];
    logic           r_den_neg  [ST_FLAGS:NST];
    logic           r_den_zero [ST_FLAGS:NST];

    // ---------------- field extraction ----------------
    logic signed [C-1:0] w_p1x, w_p1y, w_p2x, w_p2y, w_p3x, w_p3y;
    logic signed [C-1:0] w_ax, w_ay, w_bx, w_by;
    logic signed [W-1:0] w_w1, w_w2, w_w3;

    assign w_p1x = C'(r_site_x);
    assign w_p1y = C'(r_site_y);
    assign w_w1  = W'(r_site_weight);
    assign w_p2x = C'(i_s_axis_tdata[OFF_P2X +: FC]);
    assign w_p2y = C'(i_s_axis_tdata[OFF_P2Y +: FC]);
    assign w_w2  = W'(i_s_axis_tdata[OFF_W2 +: FW]);
    assign w_p3x = C'(i_s_axis_tdata[OFF_P3X +: FC]);
    assign w_p3y = C'(i_s_axis_tdata[OFF_P3Y +: FC]);
    assign w_w3  = W'(i_s_axis_tdata[OFF_W3 +: FW]);
    assign w_ax  = C'(i_s_axis_tdata[OFF_AX +: FC]);
    assign w_ay  = C'(i_s_axis_tdata[OFF_AY +: FC]);
    assign w_bx  = C'(i_s_axis_tdata[OFF_BX +: FC]);
    assign w_by  = C'(i_s_axis_tdata[OFF_BY +: FC]);

    // ---------------- stage 1: differences ----------------
    logic signed [D1-1:0] r1_t1, r1_t2, r1_t3, r1_t4, r1_t5, r1_t6;
    logic signed [D1-1:0] r1_s12x, r1_s12y, r1_s13x, r1_s13y;
    logic signed [DU-1:0] r1_u, r1_v;
    logic signed [C-1:0]  r1_ax, r1_ay;
    logic signed [WD-1:0] r1_wd12, r1_wd13, r1_wd21;

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r1_t1    <= D1'(w_p1x) - D1'(w_p2x);
            r1_t2    <= D1'(w_p1y) - D1'(w_p2y);
            r1_t3    <= D1'(w_p1x) - D1'(w_p3x);
            r1_t4    <= D1'(w_p1y) - D1'(w_p3y);
            r1_t5    <= D1'(w_ax) - D1'(w_bx);
            r1_t6    <= D1'(w_ay) - D1'(w_by);
            r1_s12x  <= D1'(w_p1x) + D1'(w_p2x);
            r1_s12y  <= D1'(w_p1y) + D1'(w_p2y);
            r1_s13x  <= D1'(w_p1x) + D1'(w_p3x);
            r1_s13y  <= D1'(w_p1y) + D1'(w_p3y);
            r1_u     <= DU'(w_ax) + DU'(w_ax) - DU'(w_p1x) - DU'(w_p2x);
            r1_v     <= DU'(w_ay) + DU'(w_ay) - DU'(w_p1y) - DU'(w_p2y);
            r1_ax    <= w_ax;
            r1_ay    <= w_ay;
            r1_wd12  <= WD'(w_w1) - WD'(w_w2);
            r1_wd13  <= WD'(w_w3) - WD'(w_w1);
            r1_wd21  <= WD'(w_w2) - WD'(w_w1);
        end
    end

    // ---------------- stage 2: first products ----------------
    logic signed [P0-1:0] r2_m0a, r2_m0b;
    logic signed [PP-1:0] r2_d1, r2_d2, r2_e1, r2_e2, r2_k1, r2_k2;
    logic signed [PC-1:0] r2_c1, r2_c2;
    logic signed [D1-1:0] r2_t1, r2_t2, r2_t3, r2_t4, r2_t5, r2_t6;
    logic signed [WD-1:0] r2_wd12, r2_wd13, r2_wd21;

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r2_m0a   <= P0'(r1_t1) * P0'(r1_u);
            r2_m0b   <= P0'(r1_t2) * P0'(r1_v);
            r2_d1    <= PP'(r1_t3) * PP'(r1_t5);
            r2_d2    <= PP'(r1_t4) * PP'(r1_t6);
            r2_e1    <= PP'(r1_t3) * PP'(r1_s13x);
            r2_e2    <= PP'(r1_t4) * PP'(r1_s13y);
            r2_k1    <= PP'(r1_t1) * PP'(r1_s12x);
            r2_k2    <= PP'(r1_t2) * PP'(r1_s12y);
            r2_c1    <= PC'(r1_ay) * PC'(r1_t5);
            r2_c2    <= PC'(r1_ax) * PC'(r1_t6);
            r2_t1    <= r1_t1;
            r2_t2    <= r1_t2;
            r2_t3    <= r1_t3;
            r2_t4    <= r1_t4;
            r2_t5    <= r1_t5;
            r2_t6    <= r1_t6;
            r2_wd12  <= r1_wd12;
            r2_wd13  <= r1_wd13;
            r2_wd21  <= r1_wd21;
        end
    end

    // ---------------- stage 3: sums ----------------
    logic signed [E0-1:0]  r3_e0;
    logic signed [DEN-1:0] r3_den;
    logic signed [DEN-1:0] n3_dsum;
    logic signed [T11-1:0] r3_t11, r3_k;
    logic signed [CW-1:0]  r3_c;
    logic signed [D1-1:0]  r3_t1, r3_t2, r3_t3, r3_t4, r3_t5, r3_t6;

    assign n3_dsum = DEN'(r2_d1) + DEN'(r2_d2);

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r3_e0    <= E0'(r2_m0a) + E0'(r2_m0b) + E0'(r2_wd12);
            r3_den   <= DEN'(0) - (n3_dsum + n3_dsum);
            r3_t11   <= T11'(r2_e1) + T11'(r2_e2) + T11'(r2_wd13);
            r3_k     <= T11'(r2_k1) + T11'(r2_k2) + T11'(r2_wd21);
            r3_c     <= CW'(r2_c1) - CW'(r2_c2);
            r3_t1    <= r2_t1;
            r3_t2    <= r2_t2;
            r3_t3    <= r2_t3;
            r3_t4    <= r2_t4;
            r3_t5    <= r2_t5;
            r3_t6    <= r2_t6;
        end
    end

    // ---------------- stage 4: second products ----------------
    logic signed [T4C-1:0] r4_t4c, r4_t3c;
    logic signed [T5T-1:0] r4_t5t11, r4_t6t11;
    logic signed [DEN-1:0] r4_den;
    logic signed [T11-1:0] r4_k;
    logic signed [D1-1:0]  r4_t1, r4_t2;

    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            r4_t4c        <= T4C'(r3_t4) * T4C'(r3_c);
            r4_t3c        <= T4C'(r3_t3) * T4C'(r3_c);
            r4_t5t11      <= T5T'(r3_t5) * T5T'(r3_t11);
            r4_t6t11      <= T5T'(r3_t6) * T5T'(r3_t11);
            r4_den        <= r3_den;
            r4_k          <= r3_k;
            r4_t1         <= r3_t1;
            r4_t2         <= r3_t2;
        end
    end

    // ---------------- stage 5: bisector terms ----------------
    logic signed [T12-1:0] r5_t12, r5_t13;
    logic signed [DEN-1:0] r5_den;
    logic signed [T11-1:0] r5_k;
    logic signed [D1-1:0]  r5_t1, r5_t2;

    always_ff @(posedge i_clk) begin
        if (en[5]) begin
            r5_t12 <= T12'(r4_t4c) + T12'(r4_t4c) - T12'(r4_t5t11);
            r5_t13 <= T12'(0) - T12'(r4_t6t11) - T12'(r4_t3c) - T12'(r4_t3c);
            r5_den <= r4_den;
            r5_k   <= r4_k;
            r5_t1  <= r4_t1;
            r5_t2  <= r4_t2;
        end
    end

    // ---------------- stages 6 and 7: wide products ----------------
    pbs_pkg::t_mul_en      w_mul_en;
    logic signed [XW-1:0]  w7_x, w7_y;
    logic signed [ZW-1:0]  w7_z;

    assign w_mul_en.load_pp  = en[ST_MUL_PP];
    assign w_mul_en.load_sum = en[ST_MUL_SUM];

    pbs_split_mul #(.A_BITS(D1), .B_BITS(T12)) u_mul_x (
        .i_clk (i_clk),
        .i_en  (w_mul_en),
        .i_a   (r5_t1),
        .i_b   (r5_t12),
        .o_p   (w7_x)
    );

    pbs_split_mul #(.A_BITS(D1), .B_BITS(T12)) u_mul_y (
        .i_clk (i_clk),
        .i_en  (w_mul_en),
        .i_a   (r5_t2),
        .i_b   (r5_t13),
        .o_p   (w7_y)
    );

    pbs_split_mul #(.A_BITS(DEN), .B_BITS(T11)) u_mul_z (
        .i_clk (i_clk),
        .i_en  (w_mul_en),
        .i_a   (r5_den),
        .i_b   (r5_k),
        .o_p   (w7_z)
    );

    // The command enters with the item and the early signs join at stage 4;
    // from there they ride along unchanged.
    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_cmd[1] <= pbs_pkg::t_cmd'(i_s_axis_tuser);
        end
        for (int k = 2; k <= NST; k++) begin
            if (en[k]) begin
                r_cmd[k] <= r_cmd[k-1];
            end
        end
        if (en[ST_FLAGS]) begin
            r_side0[ST_FLAGS]    <= pbs_pkg::side_of(r3_e0[E0-1], r3_e0 == '0);
            r_den_neg[ST_FLAGS]  <= r3_den[DEN-1];
            r_den_zero[ST_FLAGS] <= (r3_den == '0);
        end
        for (int k = ST_FLAGS + 1; k <= NST; k++) begin
            if (en[k]) begin
                r_side0[k]    <= r_side0[k-1];
                r_den_neg[k]  <= r_den_neg[k-1];
                r_den_zero[k] <= r_den_zero[k-1];
            end
        end
    end

    // ---------------- stage 8: numerator ----------------
    logic signed [NW-1:0] r8_numer;

    always_ff @(posedge i_clk) begin
        if (en[8]) begin
            r8_numer <= NW'(w7_x) + NW'(w7_x) + NW'(w7_y) + NW'(w7_y) - NW'(w7_z);
        end
    end

    // ---------------- stage 9: result sign ----------------
    pbs_pkg::t_side r9_side;
    pbs_pkg::t_side n9_side;

    always_comb begin
        case (r_cmd[8])
            pbs_pkg::CMD_POINT: n9_side = r_side0[8];
            pbs_pkg::CMD_SEGMENT: n9_side = pbs_pkg::side_of(
                r8_numer[NW-1] ^ r_den_neg[8], (r8_numer == '0) || r_den_zero[8]);
            default: n9_side = pbs_pkg::SIDE_ZERO;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en[NST]) begin
            r9_side <= n9_side;
        end
    end

    assign o_m_axis_tdata = pbs_pkg::M_TDATA_BITS'(r9_side);

    // ---------------- assertions ----------------
    logic w_in_fire;
    logic w_seg_flat;

    assign w_in_fire  = i_s_axis_tvalid && o_s_axis_tready;
    assign w_seg_flat = r_vld[NST] && (r_cmd[NST] == pbs_pkg::CMD_SEGMENT) && r_den_zero[NST];

    `ASSERT_NEXT(a_accept_fills_first_stage, i_clk, i_rst_n, w_in_fire, r_vld[1])
    `ASSERT_IMPLIES(a_bubble_opens_input, i_clk, i_rst_n, !(&r_vld), o_s_axis_tready)
    `ASSERT_IMPLIES(a_flat_denominator_is_zero, i_clk, i_rst_n, w_seg_flat, r9_side == pbs_pkg::SIDE_ZERO)

endmodule

`default_nettype wire
